@@ hdl/fad_pkg.sv @@
// Shared constants and types of the fully associative LRU tag directory.
`default_nettype none

package fad_pkg;

  localparam int AddrW       = 64;
  localparam int OffW        = 3;
  localparam int TagW        = AddrW - 3;
  localparam int FieldSlotW  = 6;
  localparam int LinesDefault = 64;
  localparam int LinesMax    = 1024;
  // Wide enough for any position or count up to LinesMax.
  localparam int PosW        = $clog2(LinesMax + 1);
  localparam int SlotMaxW    = $clog2(LinesMax);

  localparam logic [OffW-1:0] OffReset = 3'd5;
  localparam logic [OffW-1:0] OffMin   = 3'd3;
  localparam logic [OffW-1:0] OffMax   = 3'd6;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_ENC  = 4'b0100,
    S_UPD  = 4'b1000
  } fad_state_e;

  // Broadcast from the controller to every cell of the recency chain.
  typedef struct packed {
    logic                upd;
    logic [PosW-1:0]     used;
    logic [PosW-1:0]     pos;
    logic [PosW-1:0]     dest;
    logic [TagW-1:0]     tag;
    logic [SlotMaxW-1:0] slot;
  } fad_bcast_t;

endpackage

`default_nettype wire

@@ hdl/fad_intf.sv @@
// Handshake channel interfaces for the access and result words.
`default_nettype none

interface fad_addr_if;
  logic                      valid;
  logic                      ready;
  logic [fad_pkg::AddrW-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

interface fad_res_if;
  logic                           valid;
  logic                           ready;
  logic                           hit;
  logic [fad_pkg::FieldSlotW-1:0] slot;

  modport source (output valid, output hit, output slot, input ready);
  modport sink   (input valid, input hit, input slot, output ready);
endinterface

`default_nettype wire

@@ hdl/fad_cell.sv @@
// One recency position of the directory: holds a tag and its slot, shifts from its neighbor.
`default_nettype none

module fad_cell #(
  parameter int IDX    = 0,
  parameter int SLOT_W = 6
) (
  input  wire logic                      clk_i,
  input  wire fad_pkg::fad_bcast_t       bc_i,
  input  wire logic [fad_pkg::TagW-1:0]  nb_tag_i,
  input  wire logic [SLOT_W-1:0]         nb_slot_i,
  output logic                           match_o,
  output logic [fad_pkg::TagW-1:0]       tag_o,
  output logic [SLOT_W-1:0]              slot_o
);

  localparam logic [fad_pkg::PosW-1:0] MyPos = fad_pkg::PosW'(IDX);

  logic [fad_pkg::TagW-1:0] tag_q;
  logic [SLOT_W-1:0]        slot_q;
  logic                     valid;
  logic                     shift;
  logic                     load;

  // Only the first lines_used positions hold entries.
  assign valid   = MyPos < bc_i.used;
  assign match_o = valid && (tag_q == bc_i.tag);

  assign shift = bc_i.upd && (bc_i.pos <= MyPos) && (MyPos < bc_i.dest);
  assign load  = bc_i.upd && (MyPos == bc_i.dest);

  always_ff @(posedge clk_i) begin
    if (load) begin
      tag_q  <= bc_i.tag;
      slot_q <= bc_i.slot[SLOT_W-1:0];
    end else if (shift) begin
      tag_q  <= nb_tag_i;
      slot_q <= nb_slot_i;
    end
  end

  assign tag_o  = tag_q;
  assign slot_o = slot_q;

endmodule

`default_nettype wire

@@ hdl/fully_assoc_lru_tag_directory_top.sv @@
// Top level of the fully associative LRU tag directory: controller and chain of cells.
//
// Channel   Dir  Payload            Handshake
// addr_i    in   address[63:0]      valid/ready
// res_o     out  hit, slot[5:0]     valid/ready
// cfg       in   cfg_wdata_i[2:0]   cfg_we_i
//
// Each access passes through four steps: accept, compare in every cell, encode the
// matching position, then update the chain and load the result.
// The rate is set by the single compare pass and single shift of the cell chain.
// Reset empties the directory at once (lines_used goes to zero); no clearing pass.
// A result that is not taken holds the update step; the next access is still accepted
// while a finished result waits in the output register.
`default_nettype none

module fully_assoc_lru_tag_directory_top #(
  parameter int LINES = fad_pkg::LinesDefault
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [fad_pkg::OffW-1:0]  cfg_wdata_i,
  fad_addr_if.sink                       addr_i,
  fad_res_if.source                      res_o
);

  localparam int SW    = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int UsedW = $clog2(LINES + 1);
  localparam int TagW  = fad_pkg::TagW;
  localparam int PosW  = fad_pkg::PosW;

  fad_pkg::fad_state_e state_q, state_d;

  logic [fad_pkg::OffW-1:0] offset_q;
  logic [fad_pkg::OffW-1:0] sh;
  logic [TagW-1:0]          tag_q;
  logic [UsedW-1:0]         used_q;
  logic [LINES-1:0]         match_c;
  logic [LINES-1:0]         match_q;
  logic                     hit_q;
  logic [SW-1:0]            pos_q;
  logic [SW-1:0]            dest_q;
  logic [SW-1:0]            ins_slot_q;
  logic [SW-1:0]            enc_pos;
  logic [SW-1:0]            enc_slot;
  logic                     full;
  logic                     upd_go;
  logic                     in_acc;
  logic                     out_valid_q;
  logic                     out_hit_q;
  logic [fad_pkg::FieldSlotW-1:0] out_slot_q;

  logic [TagW-1:0] cell_tag  [LINES];
  logic [SW-1:0]   cell_slot [LINES];

  fad_pkg::fad_bcast_t bc;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= fad_pkg::OffReset;
    end else if (cfg_we_i) begin
      offset_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    case (offset_q) inside
      [3'd0:3'd2]: sh = fad_pkg::OffMin;
      [3'd3:3'd6]: sh = offset_q;
      default:     sh = fad_pkg::OffMax;
    endcase
  end

  assign addr_i.ready = (state_q == fad_pkg::S_IDLE);
  assign in_acc       = addr_i.valid && addr_i.ready;
  assign upd_go       = !out_valid_q || res_o.ready;
  assign full         = (used_q == UsedW'(LINES));

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      tag_q <= TagW'(addr_i.address >> sh);
    end
  end

  // Controller.
  always_comb begin
    state_d = state_q;
    case (state_q)
      fad_pkg::S_IDLE: if (in_acc) state_d = fad_pkg::S_CMP;
      fad_pkg::S_CMP:  state_d = fad_pkg::S_ENC;
      fad_pkg::S_ENC:  state_d = fad_pkg::S_UPD;
      fad_pkg::S_UPD:  if (upd_go) state_d = fad_pkg::S_IDLE;
      default:         state_d = fad_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fad_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Tags in the directory are distinct, so at most one cell matches and an OR
  // over the cells picks its position and slot.
  always_comb begin
    enc_pos  = '0;
    enc_slot = '0;
    for (int i = 0; i < LINES; i++) begin
      enc_pos  = enc_pos  | (match_q[i] ? SW'(i) : '0);
      enc_slot = enc_slot | (match_q[i] ? cell_slot[i] : '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == fad_pkg::S_CMP) begin
      match_q <= match_c;
    end
    if (state_q == fad_pkg::S_ENC) begin
      hit_q <= |match_q;
      if (|match_q) begin
        pos_q      <= enc_pos;
        dest_q     <= SW'(used_q - UsedW'(1));
        ins_slot_q <= enc_slot;
      end else if (!full) begin
        pos_q      <= SW'(used_q);
        dest_q     <= SW'(used_q);
        ins_slot_q <= SW'(used_q);
      end else begin
        pos_q      <= '0;
        dest_q     <= SW'(LINES - 1);
        ins_slot_q <= cell_slot[0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (state_q == fad_pkg::S_UPD && upd_go && !hit_q && !full) begin
      used_q <= used_q + UsedW'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == fad_pkg::S_UPD && upd_go) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == fad_pkg::S_UPD && upd_go) begin
      out_hit_q  <= hit_q;
      out_slot_q <= fad_pkg::FieldSlotW'(ins_slot_q);
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.hit   = out_hit_q;
  assign res_o.slot  = out_slot_q;

  // Broadcast to the chain.
  assign bc.upd  = (state_q == fad_pkg::S_UPD) && upd_go;
  assign bc.used = PosW'(used_q);
  assign bc.pos  = PosW'(pos_q);
  assign bc.dest = PosW'(dest_q);
  assign bc.tag  = tag_q;
  assign bc.slot = fad_pkg::SlotMaxW'(ins_slot_q);

  for (genvar g = 0; g < LINES; g++) begin : g_cell
    logic [TagW-1:0] nb_tag;
    logic [SW-1:0]   nb_slot;

    if (g < LINES - 1) begin : g_nb
      assign nb_tag  = cell_tag[g+1];
      assign nb_slot = cell_slot[g+1];
    end else begin : g_last
      assign nb_tag  = '0;
      assign nb_slot = '0;
    end

    fad_cell #(
      .IDX    (g),
      .SLOT_W (SW)
    ) u_cell (
      .clk_i     (clk_i),
      .bc_i      (bc),
      .nb_tag_i  (nb_tag),
      .nb_slot_i (nb_slot),
      .match_o   (match_c[g]),
      .tag_o     (cell_tag[g]),
      .slot_o    (cell_slot[g])
    );
  end

  // Assertions.
  a_accept_to_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == fad_pkg::S_CMP)
    else $error("accepted word did not start a compare");

  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fad_pkg::S_ENC) |-> $onehot0(match_q))
    else $error("more than one directory entry matched");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UsedW'(LINES))
    else $error("lines_used exceeds the number of lines");

  a_fill_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fad_pkg::S_UPD && upd_go && !hit_q && !full)
      |=> used_q == $past(used_q) + UsedW'(1))
    else $error("fill on miss did not advance lines_used");

endmodule

`default_nettype wire

@@ tb/sv/fad_lookup_checker.sv @@
// Passive checker that predicts every directory lookup and compares the result words.
`timescale 1ns / 1ps

module fad_lookup_checker #(
  parameter int LINES = fad_pkg::LinesDefault
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [fad_pkg::OffW-1:0] cfg_wdata_i,
  fad_addr_if                           addr_i,
  fad_res_if                            res_i,
  output int                            mismatch_count_o,
  output int                            outstanding_o
);

  typedef struct packed {
    logic                           hit;
    logic [fad_pkg::FieldSlotW-1:0] slot;
  } lookup_t;

  logic [fad_pkg::OffW-1:0] offset_cfg;
  logic [fad_pkg::TagW-1:0] line_tag [LINES];
  // Entry numbers ordered from least recent to most recent.
  int unsigned     lru_order [LINES];
  int unsigned     lines_filled;
  int              mismatches;
  lookup_t         expected_lookups [$];
  lookup_t         got;
  lookup_t         want;

  function automatic void make_most_recent(int unsigned pos);
    int unsigned entry;
    entry = lru_order[pos];
    for (int unsigned i = pos; i + 1 < lines_filled; i++) begin
      lru_order[i] = lru_order[i + 1];
    end
    lru_order[lines_filled - 1] = entry;
  endfunction

  function automatic lookup_t predict_lookup(logic [fad_pkg::AddrW-1:0] address);
    logic [fad_pkg::OffW-1:0] shift;
    logic [fad_pkg::TagW-1:0] tag;
    int unsigned              entry;
    lookup_t                  res;
    shift = offset_cfg;
    if (shift < fad_pkg::OffMin) shift = fad_pkg::OffMin;
    if (shift > fad_pkg::OffMax) shift = fad_pkg::OffMax;
    tag = fad_pkg::TagW'(address >> shift);
    for (int unsigned i = 0; i < lines_filled; i++) begin
      entry = lru_order[i];
      if (line_tag[entry] == tag) begin
        make_most_recent(i);
        res.hit  = 1'b1;
        res.slot = fad_pkg::FieldSlotW'(entry);
        return res;
      end
    end
    // Miss: fill the next free line, or recycle the least recent one.
    if (lines_filled < LINES) begin
      entry = lines_filled;
      lru_order[lines_filled] = entry;
      lines_filled++;
    end else begin
      entry = lru_order[0];
      make_most_recent(0);
    end
    line_tag[entry] = tag;
    res.hit  = 1'b0;
    res.slot = fad_pkg::FieldSlotW'(entry);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_cfg   = fad_pkg::OffReset;
      lines_filled = 0;
      mismatches   = 0;
      expected_lookups.delete();
      mismatch_count_o <= 0;
      outstanding_o    <= 0;
    end else begin
      if (cfg_we_i) offset_cfg = cfg_wdata_i;
      if (addr_i.valid && addr_i.ready) begin
        expected_lookups.push_back(predict_lookup(addr_i.address));
      end
      if (res_i.valid && res_i.ready) begin
        got.hit  = res_i.hit;
        got.slot = res_i.slot;
        if (expected_lookups.size() == 0) begin
          $display("%0t: result word with no access pending: hit=%0d slot=%0d",
                   $time, got.hit, got.slot);
          mismatches++;
        end else begin
          want = expected_lookups.pop_front();
          if (got.hit !== want.hit) begin
            $display("%0t: hit mismatch: expected %0d, actual %0d", $time, want.hit, got.hit);
            mismatches++;
          end
          if (got.slot !== want.slot) begin
            $display("%0t: slot mismatch: expected %0d, actual %0d",
                     $time, want.slot, got.slot);
            mismatches++;
          end
        end
      end
      mismatch_count_o <= mismatches;
      outstanding_o    <= expected_lookups.size();
    end
  end

endmodule

@@ tb/sv/fully_assoc_lru_tag_directory_top_test.sv @@
// Stimulus and verdict for the fully associative LRU tag directory.
`timescale 1ns / 1ps

module fully_assoc_lru_tag_directory_top_test;

  localparam int ItemsPerPhase = 145;
  localparam int PhaseCount    = 10;
  localparam int PoolDepth     = 128;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [fad_pkg::OffW-1:0]  cfg_wdata;
  int                        mismatch_count;
  int                        outstanding;
  logic                      send_idle_en;
  logic                      recv_idle_en;
  logic [fad_pkg::OffW-1:0]  off_eff;
  logic [fad_pkg::AddrW-1:0] block_pool [PoolDepth];

  fad_addr_if addr_ch ();
  fad_res_if  res_ch ();

  fully_assoc_lru_tag_directory_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .addr_i      (addr_ch),
    .res_o       (res_ch)
  );

  fad_lookup_checker #(
    .LINES (fad_pkg::LinesDefault)
  ) lookup_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .addr_i           (addr_ch),
    .res_i            (res_ch),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side: a random stall before each word, or none while idling is off.
  initial begin
    int unsigned stall;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = recv_idle_en ? $urandom_range(0, 8) : 0;
      if (stall != 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
    end
  end

  task automatic send_access(input logic [fad_pkg::AddrW-1:0] address);
    int unsigned gap;
    gap = send_idle_en ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      addr_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    addr_ch.valid   <= 1'b1;
    addr_ch.address <= address;
    do @(posedge clk); while (!addr_ch.ready);
  endtask

  // Holds the sender off until every result word has come back.
  task automatic wait_until_idle();
    addr_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_offset(input logic [fad_pkg::OffW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    off_eff = (value < fad_pkg::OffMin) ? fad_pkg::OffMin :
              (value > fad_pkg::OffMax) ? fad_pkg::OffMax : value;
  endtask

  initial begin
    int unsigned               pool_size;
    int unsigned               kind;
    int unsigned               walk_idx;
    int unsigned               sweep_idx;
    logic [fad_pkg::AddrW-1:0] sweep_base;
    logic [fad_pkg::AddrW-1:0] block_mask;
    logic [fad_pkg::AddrW-1:0] low_bits;
    logic [fad_pkg::AddrW-1:0] address;

    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    addr_ch.valid   <= 1'b0;
    addr_ch.address <= '0;
    send_idle_en    = 1'b1;
    recv_idle_en    = 1'b1;
    off_eff         = fad_pkg::OffReset;
    for (int i = 0; i < PoolDepth; i++) block_pool[i] = {$urandom, $urandom};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset offset of 5: fills, hits within a block, both address extremes.
    send_access(64'h0);
    send_access(64'h1F);
    send_access('1);
    send_access(64'hFFFF_FFFF_FFFF_FFE0);
    send_access(64'h40);
    send_access(64'h8000_0000_0000_0000);
    send_access(64'h20);
    send_access(64'h0);
    wait_until_idle();
    // Above the legal range acts as 6, so the tag stored for 0x40 now matches 0x80.
    write_offset(3'd7);
    send_access(64'h80);
    send_access(64'hBF);
    send_access(64'hC0);
    wait_until_idle();
    // Below the legal range acts as 3; old tags are compared against the narrower shift.
    write_offset(3'd0);
    send_access(64'h10);
    send_access(64'h8);
    send_access(64'h7);
    send_access('1);
    wait_until_idle();

    for (int p = 0; p < PhaseCount; p++) begin
      // Stepping by 5 modulo 8 visits every offset value, legal or not.
      write_offset(fad_pkg::OffW'(6 + 5 * p));
      for (int i = 0; i < PoolDepth; i++) begin
        if ($urandom_range(0, 3) == 0) block_pool[i] = {$urandom, $urandom};
      end
      pool_size  = (p == 0) ? 70 : $urandom_range(4, 100);
      walk_idx   = 0;
      sweep_idx  = 0;
      sweep_base = {$urandom, $urandom};
      if (p < 2) {send_idle_en, recv_idle_en} = 2'b11;
      else {send_idle_en, recv_idle_en} = 2'($urandom_range(0, 3));
      block_mask = (64'd1 << off_eff) - 64'd1;
      for (int n = 0; n < ItemsPerPhase; n++) begin
        kind     = $urandom_range(0, 99);
        low_bits = {$urandom, $urandom} & block_mask;
        if (kind < 60) begin
          address = (block_pool[$urandom_range(0, pool_size - 1)] & ~block_mask) | low_bits;
        end else if (kind < 75) begin
          // Cyclic walk: thrashes the LRU order once the pool exceeds the line count.
          address  = (block_pool[walk_idx] & ~block_mask) | low_bits;
          walk_idx = (walk_idx + 1) % pool_size;
        end else if (kind < 90) begin
          address   = sweep_base + (fad_pkg::AddrW'(sweep_idx) << off_eff) + low_bits;
          sweep_idx = sweep_idx + 1;
        end else begin
          address = {$urandom, $urandom};
        end
        send_access(address);
      end
      wait_until_idle();
    end

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
